/* rtl/wgr_pkg.sv */
// Types and constants shared by the card reader receiver modules.
`timescale 1ns / 1ps

package wgr_pkg;

    localparam int PORT_W    = 8;
    localparam int POS_W     = 3;
    localparam int GROUP_W   = 8;
    localparam int TIMEOUT_W = 16;
    localparam int CODE_W    = 64;
    localparam int COUNT_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = TIMEOUT_W;

    localparam logic [POS_W-1:0]     D0_POS_RESET  = 3'd0;
    localparam logic [POS_W-1:0]     D1_POS_RESET  = 3'd1;
    localparam logic [GROUP_W-1:0]   GROUP_RESET   = 8'd0;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd100;

    localparam logic [COUNT_W-1:0]   COUNT_MAX = 8'd255;
    localparam logic [TIMEOUT_W-1:0] MS_MAX    = 16'hFFFF;

    localparam logic [COUNT_W-1:0] LEN_W26 = 8'd26;
    localparam logic [COUNT_W-1:0] LEN_W34 = 8'd34;
    localparam logic [COUNT_W-1:0] LEN_W58 = 8'd58;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_D0_POS  = 2'd0,
        CFG_D1_POS  = 2'd1,
        CFG_GROUP   = 2'd2,
        CFG_TIMEOUT = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [PORT_W-1:0] port_sample;
        logic              ms_tick;
    } sample_item_t;

    typedef struct packed {
        logic [CODE_W-1:0]  card_uid;
        logic [COUNT_W-1:0] raw_bit_count;
        logic [GROUP_W-1:0] card_group;
    } card_item_t;

    typedef struct packed {
        logic [POS_W-1:0]     d0_pos;
        logic [POS_W-1:0]     d1_pos;
        logic [GROUP_W-1:0]   group;
        logic [TIMEOUT_W-1:0] timeout;
    } cfg_t;

endpackage

/* rtl/wgr_sample_if.sv */
// Channel carrying sampled port items into the receiver.
`timescale 1ns / 1ps

interface wgr_sample_if;
    import wgr_pkg::*;

    logic         valid;
    logic         ready;
    sample_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/wgr_card_if.sv */
// Channel carrying decoded card items out of the receiver.
`timescale 1ns / 1ps

interface wgr_card_if;
    import wgr_pkg::*;

    logic       valid;
    logic       ready;
    card_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/wgr_cfg_regs.sv */
// Configuration register file with a plain write port.
`timescale 1ns / 1ps

module wgr_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [wgr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wgr_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output wgr_pkg::cfg_t                 cfg
);
    import wgr_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_D0_POS:  cfg_next.d0_pos  = cfg_wdata[POS_W-1:0];
                CFG_D1_POS:  cfg_next.d1_pos  = cfg_wdata[POS_W-1:0];
                CFG_GROUP:   cfg_next.group   = cfg_wdata[GROUP_W-1:0];
                CFG_TIMEOUT: cfg_next.timeout = cfg_wdata[TIMEOUT_W-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.d0_pos  <= D0_POS_RESET;
            cfg_reg.d1_pos  <= D1_POS_RESET;
            cfg_reg.group   <= GROUP_RESET;
            cfg_reg.timeout <= TIMEOUT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/wgr_in_stage.sv */
// Input register holding one sampled item until the decoder takes it.
`timescale 1ns / 1ps

module wgr_in_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    wgr_sample_if.sink            sample_ch,
    input  logic                  advance,
    output logic                  item_valid,
    output wgr_pkg::sample_item_t item
);
    import wgr_pkg::*;

    logic         valid_reg;
    logic         valid_next;
    sample_item_t item_reg;
    logic         take;

    assign sample_ch.ready = !valid_reg || advance;
    assign take            = sample_ch.valid && sample_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= sample_ch.data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* rtl/wgr_decoder.sv */
// Edge detection, code shift register, bit count, silence timer and frame end.
`timescale 1ns / 1ps

module wgr_decoder (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  wgr_pkg::sample_item_t item,
    input  wgr_pkg::cfg_t         cfg,
    output logic                  emit,
    output wgr_pkg::card_item_t   card
);
    import wgr_pkg::*;

    logic                 prev_d0_reg;
    logic                 prev_d1_reg;
    logic [CODE_W-1:0]    code_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [TIMEOUT_W-1:0] ms_reg;

    logic                 prev_d0_next;
    logic                 prev_d1_next;
    logic [CODE_W-1:0]    code_next;
    logic [COUNT_W-1:0]   count_next;
    logic [TIMEOUT_W-1:0] ms_next;

    logic                 d0;
    logic                 d1;
    logic                 fall0;
    logic                 fall1;
    logic                 any_fall;
    logic [TIMEOUT_W-1:0] ms_ticked;
    logic [TIMEOUT_W-1:0] ms_new;
    logic [CODE_W-1:0]    code_new;
    logic [COUNT_W:0]     count_sum;
    logic [COUNT_W-1:0]   count_new;
    logic [CODE_W-1:0]    uid;

    assign d0       = item.port_sample[cfg.d0_pos];
    assign d1       = item.port_sample[cfg.d1_pos];
    assign fall0    = prev_d0_reg && !d0;
    assign fall1    = prev_d1_reg && !d1;
    assign any_fall = fall0 || fall1;

    assign ms_ticked = (item.ms_tick && ms_reg != MS_MAX) ? ms_reg + 16'd1 : ms_reg;
    assign ms_new    = any_fall ? '0 : ms_ticked;

    always_comb
    begin
        unique case ({fall0, fall1})
            2'b11:   code_new = {code_reg[CODE_W-3:0], 2'b01};
            2'b10:   code_new = {code_reg[CODE_W-2:0], 1'b0};
            2'b01:   code_new = {code_reg[CODE_W-2:0], 1'b1};
            default: code_new = code_reg;
        endcase
    end

    assign count_sum = {1'b0, count_reg} + {{(COUNT_W-1){1'b0}}, fall0 && fall1, fall0 ^ fall1};
    assign count_new = (count_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : count_sum[COUNT_W-1:0];

    assign emit = advance && (count_new != '0) &&
                  ((ms_new > cfg.timeout) || (ms_new == MS_MAX));

    always_comb
    begin
        priority if (count_new == LEN_W26)
        begin
            uid = {40'b0, code_new[24:1]};
        end
        else if (count_new == LEN_W34)
        begin
            uid = {32'b0, code_new[32:1]};
        end
        else if (count_new == LEN_W58)
        begin
            uid = {8'b0, code_new[56:1]};
        end
        else
        begin
            uid = code_new;
        end
    end

    assign card.card_uid      = uid;
    assign card.raw_bit_count = count_new;
    assign card.card_group    = cfg.group;

    always_comb
    begin
        prev_d0_next = prev_d0_reg;
        prev_d1_next = prev_d1_reg;
        code_next    = code_reg;
        count_next   = count_reg;
        ms_next      = ms_reg;
        if (advance)
        begin
            prev_d0_next = d0;
            prev_d1_next = d1;
            ms_next      = ms_new;
            code_next    = emit ? '0 : code_new;
            count_next   = emit ? '0 : count_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_d0_reg <= 1'b1;
            prev_d1_reg <= 1'b1;
            code_reg    <= '0;
            count_reg   <= '0;
            ms_reg      <= '0;
        end
        else
        begin
            prev_d0_reg <= prev_d0_next;
            prev_d1_reg <= prev_d1_next;
            code_reg    <= code_next;
            count_reg   <= count_next;
            ms_reg      <= ms_next;
        end
    end

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (count_reg == '0 && code_reg == '0))
        else $error("frame end did not clear code and count");

    a_fall_clears_timer: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && any_fall) |=> ms_reg == '0)
        else $error("bit edge did not clear silence timer");

    a_empty_code: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> code_reg == '0)
        else $error("code holds bits with zero count");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(count_reg) && $stable(ms_reg) && $stable(code_reg)))
        else $error("state moved without an item");

endmodule

/* rtl/wgr_out_stage.sv */
// Result register holding one card item until the sink takes it.
`timescale 1ns / 1ps

module wgr_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  wgr_pkg::card_item_t card,
    output logic                free,
    wgr_card_if.source          card_ch
);
    import wgr_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    card_item_t card_reg;

    assign free = !valid_reg || card_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (card_ch.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            card_reg <= card;
        end
    end

    assign card_ch.valid = valid_reg;
    assign card_ch.data  = card_reg;

endmodule

/* rtl/wiegand_receiver.sv */
// Top level of the two-wire card reader receiver.
`timescale 1ns / 1ps
//
// sample_ch takes one item per pass of the pin sampler: the port byte that
// holds both data lines and a millisecond tick flag. card_ch delivers one
// item per finished frame: the cleaned card code, the raw bit count and the
// reader group. Configuration is written through cfg_wr_en / cfg_index /
// cfg_wdata while the block is idle.
//
// An accepted item sits in the input register until the decoder takes it.
// The decoder then updates its state and, at a frame end, loads the
// result register, so a result reaches card_ch only after the item that
// ended the frame has passed through the input register. One item is
// taken every cycle as long as the result register is empty or being
// drained.
//
// Reset clears both registers' valid flags, sets the line levels to idle
// high, empties the code and count and loads the register defaults.
// When card_ch stalls with a result waiting, the input register still takes
// one item; further items wait until the result is taken.
//
module wiegand_receiver (
    input  logic                           clk,
    input  logic                           rst_n,
    wgr_sample_if.sink                     sample_ch,
    wgr_card_if.source                     card_ch,
    input  logic                           cfg_wr_en,
    input  logic [wgr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wgr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import wgr_pkg::*;

    cfg_t         cfg;
    logic         item_valid;
    sample_item_t item;
    logic         out_free;
    logic         advance;
    logic         emit;
    card_item_t   card;

    assign advance = item_valid && out_free;

    wgr_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    wgr_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_ch  (sample_ch),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    wgr_decoder u_dec (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item),
        .cfg     (cfg),
        .emit    (emit),
        .card    (card)
    );

    wgr_out_stage u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (emit),
        .card    (card),
        .free    (out_free),
        .card_ch (card_ch)
    );

    a_item_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !advance) |=> item_valid)
        else $error("pending item dropped");

    a_no_load_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> out_free)
        else $error("result loaded over a waiting result");

    a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> card_ch.valid)
        else $error("result not presented");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the two-wire card reader receiver.
`timescale 1ns / 1ps

module testbench;
    import wgr_pkg::*;

    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 4;
    localparam int RANDOM_ITEMS = 600;
    localparam int RANDOM_CARDS = 10;
    localparam int PHASE_ITEMS  = 200;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    wgr_sample_if sample_ch ();
    wgr_card_if   card_ch ();

    wiegand_receiver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .card_ch   (card_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    logic [POS_W-1:0]     m_d0_pos;
    logic [POS_W-1:0]     m_d1_pos;
    logic [GROUP_W-1:0]   m_group;
    logic [TIMEOUT_W-1:0] m_timeout;
    logic                 m_prev_d0;
    logic                 m_prev_d1;
    logic [CODE_W-1:0]    m_code;
    logic [COUNT_W-1:0]   m_count;
    logic [TIMEOUT_W-1:0] m_quiet_ms;

    card_item_t expected_cards[$];
    int         mismatches;
    int         items_sent;
    int         cards_due;
    bit         idle_en;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic chance(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic void shift_in(logic b);
        m_code = {m_code[CODE_W-2:0], b};
        if (m_count != COUNT_MAX)
            m_count = m_count + 8'd1;
        m_quiet_ms = '0;
    endfunction

    function automatic void decode_sample(logic [PORT_W-1:0] port, logic tick);
        logic       d0;
        logic       d1;
        card_item_t card;
        d0 = port[m_d0_pos];
        d1 = port[m_d1_pos];
        if (tick && m_quiet_ms != MS_MAX)
            m_quiet_ms = m_quiet_ms + 16'd1;
        if (!d0 && m_prev_d0)
            shift_in(1'b0);
        if (!d1 && m_prev_d1)
            shift_in(1'b1);
        m_prev_d0 = d0;
        m_prev_d1 = d1;
        if (m_count != '0 && (m_quiet_ms > m_timeout || m_quiet_ms == MS_MAX))
        begin
            case (m_count)
                LEN_W26: card.card_uid = {40'd0, m_code[24:1]};
                LEN_W34: card.card_uid = {32'd0, m_code[32:1]};
                LEN_W58: card.card_uid = {8'd0, m_code[56:1]};
                default: card.card_uid = m_code;
            endcase
            card.raw_bit_count = m_count;
            card.card_group    = m_group;
            expected_cards.insert(expected_cards.size(), card);
            cards_due++;
            m_code  = '0;
            m_count = '0;
        end
    endfunction

    function automatic logic [PORT_W-1:0] line_levels(logic d0, logic d1);
        logic [PORT_W-1:0] port;
        port = PORT_W'($urandom);
        port[m_d0_pos] = d0;
        port[m_d1_pos] = d1;
        return port;
    endfunction

    task automatic send_sample(logic [PORT_W-1:0] port, logic tick);
        int gap;
        if (idle_en && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 5);
            sample_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.valid            = 1'b1;
        sample_ch.data.port_sample = port;
        sample_ch.data.ms_tick     = tick;
        do @(posedge clk); while (!sample_ch.ready);
        decode_sample(port, tick);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_bit(logic b, int tick_pct);
        send_sample(b ? line_levels(1'b1, 1'b0) : line_levels(1'b0, 1'b1), chance(tick_pct));
        send_sample(line_levels(1'b1, 1'b1), chance(tick_pct));
    endtask

    task automatic send_frame(int nbits, int tick_pct);
        repeat (nbits) send_bit(1'($urandom_range(0, 1)), tick_pct);
    endtask

    task automatic close_frame(int tick_pct);
        while (m_count != '0)
            send_sample(line_levels(1'b1, 1'b1), chance(tick_pct));
    endtask

    task automatic wait_drained();
        sample_ch.valid = 1'b0;
        while (expected_cards.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        case (idx)
            CFG_D0_POS:  m_d0_pos  = value[POS_W-1:0];
            CFG_D1_POS:  m_d1_pos  = value[POS_W-1:0];
            CFG_GROUP:   m_group   = value[GROUP_W-1:0];
            CFG_TIMEOUT: m_timeout = value[TIMEOUT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(logic [POS_W-1:0] d0_pos, logic [POS_W-1:0] d1_pos,
                                 logic [GROUP_W-1:0] group, logic [TIMEOUT_W-1:0] timeout);
        logic [CFG_DATA_W-1:0] value;
        if (m_count != '0)
            close_frame(100);
        wait_drained();
        value = CFG_DATA_W'($urandom);
        value[POS_W-1:0] = d0_pos;
        write_reg(CFG_D0_POS, value);
        value = CFG_DATA_W'($urandom);
        value[POS_W-1:0] = d1_pos;
        write_reg(CFG_D1_POS, value);
        value = CFG_DATA_W'($urandom);
        value[GROUP_W-1:0] = group;
        write_reg(CFG_GROUP, value);
        write_reg(CFG_TIMEOUT, timeout);
    endtask

    task automatic test_default_frame();
        send_frame(26, 0);
        close_frame(100);
    endtask

    task automatic test_frame_formats();
        apply_setting(3'd7, 3'd0, 8'hFF, 16'd1);
        send_frame(26, 0);
        close_frame(100);
        send_frame(34, 0);
        close_frame(100);
        send_frame(58, 0);
        close_frame(100);
        send_frame(1, 0);
        close_frame(100);
        send_frame(64, 0);
        close_frame(100);
        send_frame(65, 0);
        close_frame(100);
    endtask

    task automatic test_simultaneous_edges();
        apply_setting(3'd2, 3'd5, 8'h3C, 16'd2);
        send_bit(1'b1, 0);
        send_sample(line_levels(1'b0, 1'b0), 1'b0);
        send_sample(line_levels(1'b1, 1'b1), 1'b0);
        send_bit(1'b0, 0);
        close_frame(100);
    endtask

    task automatic test_shared_line();
        apply_setting(3'd3, 3'd3, 8'hA5, 16'd1);
        send_frame(6, 0);
        close_frame(100);
    endtask

    task automatic test_long_frame();
        apply_setting(3'd0, 3'd1, 8'h5A, 16'd1);
        send_frame(40, 0);
        repeat (110)
        begin
            send_sample(line_levels(1'b0, 1'b0), 1'b0);
            send_sample(line_levels(1'b1, 1'b1), 1'b0);
        end
        close_frame(100);
    endtask

    task automatic test_zero_timeout();
        apply_setting(3'd1, 3'd6, 8'h00, 16'd0);
        send_frame(3, 0);
        close_frame(100);
        send_frame(8, 50);
        close_frame(100);
    endtask

    task automatic test_max_timeout();
        apply_setting(3'd4, 3'd6, 8'h81, MS_MAX);
        send_frame(3, 0);
        repeat (100) send_sample(line_levels(1'b1, 1'b1), 1'b1);
        wait_drained();
        write_reg(CFG_TIMEOUT, 16'd120);
        close_frame(100);
    endtask

    task automatic test_random();
        int                   start_items;
        int                   start_cards;
        int                   phase_end;
        int                   pick;
        int                   nbits;
        logic [POS_W-1:0]     d0_pos;
        logic [POS_W-1:0]     d1_pos;
        logic [GROUP_W-1:0]   group;
        logic [TIMEOUT_W-1:0] timeout;
        start_items = items_sent;
        start_cards = cards_due;
        while (items_sent - start_items < RANDOM_ITEMS || cards_due - start_cards < RANDOM_CARDS)
        begin
            d0_pos = 3'($urandom_range(0, 7));
            d1_pos = chance(15) ? d0_pos : 3'($urandom_range(0, 7));
            case ($urandom_range(0, 4))
                0: group = 8'h00;
                1: group = 8'hFF;
                default: group = 8'($urandom);
            endcase
            timeout = chance(10) ? 16'($urandom_range(7, 40)) : 16'($urandom_range(0, 6));
            apply_setting(d0_pos, d1_pos, group, timeout);
            if (items_sent - start_items > RANDOM_ITEMS * 4 / 5)
                idle_en = 1'b0;
            else
                idle_en = $urandom_range(0, 3) != 0;
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
            begin
                if (items_sent - start_items >= RANDOM_ITEMS * 4 / 5)
                begin
                    idle_en = 1'b0;
                end
                pick = $urandom_range(0, 9);
                if (pick < 7)
                begin
                    case ($urandom_range(0, 9))
                        0: nbits = 26;
                        1: nbits = 34;
                        2: nbits = 58;
                        3: nbits = $urandom_range(13, 100);
                        default: nbits = $urandom_range(1, 12);
                    endcase
                    send_frame(nbits, 6);
                    close_frame(75);
                end
                else if (pick < 9)
                begin
                    repeat ($urandom_range(1, 10))
                        send_sample(PORT_W'($urandom), 1'($urandom_range(0, 1)));
                end
                else
                begin
                    send_sample(line_levels(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))),
                                1'b0);
                    repeat ($urandom_range(1, 4))
                        send_sample(PORT_W'($urandom), 1'($urandom_range(0, 1)));
                end
            end
        end
    endtask

    initial
    begin
        int stall_left;
        stall_left    = 0;
        card_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                card_ch.ready = 1'b0;
                stall_left--;
            end
            else if (idle_en && $urandom_range(0, 7) == 0)
            begin
                card_ch.ready = 1'b0;
                stall_left    = $urandom_range(0, 4);
            end
            else
            begin
                card_ch.ready = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        card_item_t want;
        if (card_ch.valid && card_ch.ready)
        begin
            if (expected_cards.size() == 0)
            begin
                $error("card item with none expected: card_uid %h raw_bit_count %0d",
                       card_ch.data.card_uid, card_ch.data.raw_bit_count);
                mismatches++;
            end
            else
            begin
                want = expected_cards.pop_front();
                if (card_ch.data.card_uid !== want.card_uid)
                begin
                    $error("card_uid: expected %h, actual %h",
                           want.card_uid, card_ch.data.card_uid);
                    mismatches++;
                end
                if (card_ch.data.raw_bit_count !== want.raw_bit_count)
                begin
                    $error("raw_bit_count: expected %0d, actual %0d",
                           want.raw_bit_count, card_ch.data.raw_bit_count);
                    mismatches++;
                end
                if (card_ch.data.card_group !== want.card_group)
                begin
                    $error("card_group: expected %0d, actual %0d",
                           want.card_group, card_ch.data.card_group);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((sample_ch.valid && sample_ch.ready) || (card_ch.valid && card_ch.ready)
                || cfg_wr_en)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("wiegand_receiver regression: fail");
        $finish;
    end

    initial
    begin
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = CFG_D0_POS;
        cfg_wdata       = '0;
        sample_ch.valid = 1'b0;
        sample_ch.data  = '0;
        idle_en         = 1'b1;
        mismatches      = 0;
        items_sent      = 0;
        cards_due       = 0;
        m_d0_pos        = D0_POS_RESET;
        m_d1_pos        = D1_POS_RESET;
        m_group         = GROUP_RESET;
        m_timeout       = TIMEOUT_RESET;
        m_prev_d0       = 1'b1;
        m_prev_d1       = 1'b1;
        m_code          = '0;
        m_count         = '0;
        m_quiet_ms      = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        test_default_frame();
        test_frame_formats();
        test_simultaneous_edges();
        test_shared_line();
        test_long_frame();
        test_zero_timeout();
        test_max_timeout();
        test_random();

        wait_drained();
        repeat (8) @(negedge clk);
        if (mismatches == 0 && expected_cards.size() == 0)
            $display("wiegand_receiver regression: pass");
        else
            $display("wiegand_receiver regression: fail");
        $finish;
    end

endmodule

/* filelist.f */
rtl/wgr_pkg.sv
rtl/wgr_sample_if.sv
rtl/wgr_card_if.sv
rtl/wgr_cfg_regs.sv
rtl/wgr_in_stage.sv
rtl/wgr_decoder.sv
rtl/wgr_out_stage.sv
rtl/wiegand_receiver.sv
tb/testbench.sv
